### rtl/ubr_pkg.sv
// Package for the unstuffing bit reader: sizes, status codes, payload and command types.
// No dependencies.
package ubr_pkg;

    localparam int STORE_BITS = 32;
    localparam int MAX_TAKE   = 16;
    localparam int HELD_W     = $clog2(STORE_BITS + 1);
    localparam int TAKE_W     = 16;
    localparam int COUNT_W    = 5;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] FF_BYTE    = 8'hFF;
    localparam logic [7:0] STUFF_ZERO = 8'h00;

    localparam logic       ACT_PUSH = 1'b0;
    localparam logic       ACT_TAKE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FEW    = 2'd1;
    localparam logic [1:0] ST_MARKER = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic               action;
        logic [7:0]         byte_value;
        logic [COUNT_W-1:0] bit_count;
    } t_in;

    typedef struct packed {
        logic [TAKE_W-1:0] taken_bits;
        logic [1:0]        status;
        logic [HELD_W-1:0] buffered_bits;
    } t_out;

    // decoded request as it travels from front to back
    typedef struct packed {
        logic               is_take;
        logic [7:0]         data;
        logic               is_ff;
        logic               is_zero;
        logic [COUNT_W-1:0] want;
    } t_cmd;

endpackage

### rtl/ubr_front.sv
// Front end: decodes an incoming request into a command for the back end.
// Depends on ubr_pkg.
module ubr_front (
    input  ubr_pkg::t_in  i_req,
    output ubr_pkg::t_cmd o_cmd
);

    logic w_over;

    assign w_over = (i_req.bit_count > ubr_pkg::COUNT_W'(ubr_pkg::MAX_TAKE));

    always_comb begin
        o_cmd.is_take = (i_req.action == ubr_pkg::ACT_TAKE);
        o_cmd.data    = i_req.byte_value;
        o_cmd.is_ff   = (i_req.byte_value == ubr_pkg::FF_BYTE);
        o_cmd.is_zero = (i_req.byte_value == ubr_pkg::STUFF_ZERO);
        o_cmd.want    = w_over ? ubr_pkg::COUNT_W'(ubr_pkg::MAX_TAKE) : i_req.bit_count;
    end

endmodule

### rtl/ubr_queue.sv
// Short command queue between front and back end.
// Depends on ubr_pkg.
module ubr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ubr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ubr_pkg::t_cmd o_cmd
);

    ubr_pkg::t_cmd                  r_mem [ubr_pkg::QDEPTH];
    logic [ubr_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [ubr_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [ubr_pkg::QCNT_W-1:0]     r_count,  n_count;

    assign o_full  = (r_count == ubr_pkg::QCNT_W'(ubr_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == ubr_pkg::QPTR_W'(ubr_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == ubr_pkg::QPTR_W'(ubr_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

### rtl/ubr_back.sv
// Back end: unstuffing state, bit buffer and the result register.
// Depends on ubr_pkg.
module ubr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  ubr_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ubr_pkg::t_out o_out
);

    localparam int SW = ubr_pkg::STORE_BITS;
    localparam int HW = ubr_pkg::HELD_W;
    localparam int TW = ubr_pkg::TAKE_W;

    logic [SW-1:0]   r_store,   n_store;
    logic [HW-1:0]   r_held,    n_held;
    logic            r_pending, n_pending;
    logic            r_marker,  n_marker;
    logic            r_out_valid;
    ubr_pkg::t_out   r_out,     n_out;

    logic            w_fits;
    logic [7:0]      w_byte;
    logic            w_append;
    logic [HW-1:0]   w_want;
    logic [HW-1:0]   w_rest;
    logic [SW-1:0]   w_shifted;
    logic [TW-1:0]   w_tmask;

    // next request may enter when the result register is empty or draining
    assign o_pop = i_cmd_valid && (!r_out_valid || i_out_ready);

    assign w_fits    = ({1'b0, r_held} + (HW + 1)'(8)) <= (HW + 1)'(SW);
    assign w_byte    = r_pending ? ubr_pkg::FF_BYTE : i_cmd.data;
    assign w_want    = HW'(i_cmd.want);
    assign w_rest    = r_held - w_want;
    assign w_shifted = r_store >> w_rest;
    assign w_tmask   = ~({TW{1'b1}} << i_cmd.want);

    always_comb begin
        n_store   = r_store;
        n_held    = r_held;
        n_pending = r_pending;
        n_marker  = r_marker;
        w_append  = 1'b0;
        n_out.taken_bits = '0;
        n_out.status     = ubr_pkg::ST_OK;

        if (!i_cmd.is_take) begin
            if (r_marker) begin
                n_out.status = ubr_pkg::ST_MARKER;
            end else if (r_pending) begin
                n_pending = 1'b0;
                if (i_cmd.is_zero) begin
                    w_append = 1'b1;
                end else begin
                    n_marker     = 1'b1;
                    n_out.status = ubr_pkg::ST_MARKER;
                end
            end else if (i_cmd.is_ff) begin
                n_pending = 1'b1;
            end else begin
                w_append = 1'b1;
            end
            if (w_append) begin
                if (w_fits) begin
                    n_store = {r_store[SW-9:0], w_byte};
                    n_held  = r_held + HW'(8);
                end else begin
                    n_out.status = ubr_pkg::ST_FULL;
                end
            end
        end else if (i_cmd.want != '0) begin
            if (r_held >= w_want) begin
                n_out.taken_bits = w_shifted[TW-1:0] & w_tmask;
                n_held  = w_rest;
                n_store = r_store & ~({SW{1'b1}} << w_rest);
            end else begin
                n_out.status = r_marker ? ubr_pkg::ST_MARKER : ubr_pkg::ST_FEW;
            end
        end
        n_out.buffered_bits = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store     <= '0;
            r_held      <= '0;
            r_pending   <= 1'b0;
            r_marker    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_store   <= n_store;
                r_held    <= n_held;
                r_pending <= n_pending;
                r_marker  <= n_marker;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(SW))
        else $error("bit count above buffer size");

    a_marker_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_marker |=> r_marker)
        else $error("marker flag dropped");

    a_pending_vs_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending && r_marker))
        else $error("pending 0xFF after marker");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out.buffered_bits == r_held))
        else $error("reported bit count differs from buffer");

endmodule

### rtl/unstuffing_bit_reader.sv
// Top level of the unstuffing bit reader: front decode, command queue, back end.
// Depends on ubr_pkg, ubr_front, ubr_queue, ubr_back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in  (action, byte, count)
//  out     | output    | o_out_valid / i_out_ready | o_out (bits, status, count)
//
// One request per cycle sustained while the output is not stalled; each request updates
// the bit buffer in the back end, which is the only loop (state of one request feeds the next).
// An accepted request is written into the queue, then the back end registers its result.
// Reset is synchronous and empties the buffer, the queue and the result register.
// A stalled output holds its result; the two-entry queue keeps accepting until full.
module unstuffing_bit_reader (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ubr_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ubr_pkg::t_out o_out
);

    ubr_pkg::t_cmd w_dec_cmd;
    ubr_pkg::t_cmd w_q_cmd;
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_push;
    logic          w_pop;

    assign o_in_ready = !w_q_full;
    assign w_push     = i_in_valid && !w_q_full;

    ubr_front u_front (
        .i_req (i_in),
        .o_cmd (w_dec_cmd)
    );

    ubr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_dec_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    ubr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### sim/tb.sv
// Self-checking bench for unstuffing_bit_reader: queue-fed driver, clocked monitor, predictor.
// Depends on ubr_pkg and the reader RTL; stream bytes and takes come from $urandom.
module tb;
    import ubr_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_req    = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    unstuffing_bit_reader u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    t_in  pending_requests[$];
    t_out predicted_results[$];

    // predictor copy of the reader state
    logic [STORE_BITS-1:0] model_store = '0;
    int                    model_held  = 0;
    logic                  model_ff_wait = 1'b0;
    logic                  model_marker  = 1'b0;

    int fail_count = 0;
    int result_count = 0;

    function automatic logic [1:0] store_append(input logic [7:0] b);
        if (model_held + 8 > STORE_BITS) return ST_FULL;
        model_store = {model_store[STORE_BITS-9:0], b};
        model_held  = model_held + 8;
        return ST_OK;
    endfunction

    function automatic t_out reader_predict(input t_in req);
        t_out        res;
        int          want;
        int          rest;
        logic [63:0] wide;
        logic [63:0] picked;
        res = '0;
        res.status = ST_OK;
        if (req.action == ACT_PUSH) begin
            if (model_marker) begin
                res.status = ST_MARKER;
            end else if (model_ff_wait) begin
                model_ff_wait = 1'b0;
                if (req.byte_value == STUFF_ZERO) begin
                    res.status = store_append(FF_BYTE);
                end else begin
                    model_marker = 1'b1;
                    res.status = ST_MARKER;
                end
            end else if (req.byte_value == FF_BYTE) begin
                model_ff_wait = 1'b1;
            end else begin
                res.status = store_append(req.byte_value);
            end
        end else begin
            want = (int'(req.bit_count) > MAX_TAKE) ? MAX_TAKE : int'(req.bit_count);
            if (want != 0) begin
                if (model_held >= want) begin
                    rest   = model_held - want;
                    wide   = 64'(model_store);
                    picked = (wide >> rest) & ((64'd1 << want) - 64'd1);
                    res.taken_bits = picked[TAKE_W-1:0];
                    wide = wide & ((64'd1 << rest) - 64'd1);
                    model_store = wide[STORE_BITS-1:0];
                    model_held  = rest;
                end else begin
                    res.status = model_marker ? ST_MARKER : ST_FEW;
                end
            end
        end
        res.buffered_bits = HELD_W'(model_held);
        return res;
    endfunction

    // driver: one request held until accepted, random gap before the next
    int tx_gap  = 0;
    int tx_calm = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) predicted_results.push_back(reader_predict(in_req));
            if (!in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    in_req   <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm = tx_calm - 1;
                        tx_gap  = 0;
                    end else begin
                        if ($urandom_range(0, 29) == 0) tx_calm = 40;
                        tx_gap = $urandom_range(0, 3);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    int   rx_wait = 0;
    int   rx_calm = 0;
    int   rx_hold = 0;
    logic hold_done = 1'b0;
    t_out want_res;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                result_count = result_count + 1;
                if (predicted_results.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result: bits %h status %0d held %0d",
                                 o_out.taken_bits, o_out.status, o_out.buffered_bits);
                end else begin
                    want_res = predicted_results.pop_front();
                    if (o_out.taken_bits !== want_res.taken_bits ||
                        o_out.status !== want_res.status ||
                        o_out.buffered_bits !== want_res.buffered_bits) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch: bits %h/%h status %0d/%0d held %0d/%0d",
                                     want_res.taken_bits, o_out.taken_bits,
                                     want_res.status, o_out.status,
                                     want_res.buffered_bits, o_out.buffered_bits);
                    end
                end
                if (rx_calm > 0) begin
                    rx_calm = rx_calm - 1;
                    rx_wait = 0;
                end else begin
                    if ($urandom_range(0, 29) == 0) rx_calm = 40;
                    rx_wait = $urandom_range(0, 3);
                end
            end
            // one long back-pressure stretch to fill the internal queue
            if (!hold_done && result_count >= 300) begin
                hold_done = 1'b1;
                rx_hold   = 250;
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_push(input logic [7:0] b);
        t_in r;
        r = '0;
        r.action = ACT_PUSH;
        r.byte_value = b;
        r.bit_count = COUNT_W'($urandom);
        pending_requests.push_back(r);
    endtask

    task automatic queue_take(input int cnt);
        t_in r;
        r = '0;
        r.action = ACT_TAKE;
        r.byte_value = 8'($urandom);
        r.bit_count = COUNT_W'(cnt);
        pending_requests.push_back(r);
    endtask

    function automatic int random_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 0;
        if (pick == 1) return $urandom_range(17, 31);
        if (pick == 2) return MAX_TAKE;
        return $urandom_range(1, 16);
    endfunction

    initial begin
        int         n;
        logic [7:0] b;
        // directed: empty takes, stuffing, full buffer, saturated counts
        queue_take(0);
        queue_take(1);
        queue_take(16);
        queue_push(8'h00);
        queue_push(FF_BYTE);
        queue_push(STUFF_ZERO);
        queue_push(8'h80);
        queue_push(8'h01);
        queue_push(8'h7F);
        queue_push(FF_BYTE);
        queue_push(STUFF_ZERO);
        queue_take(31);
        queue_take(0);
        queue_take(17);
        queue_take(1);
        queue_push(8'hAA);
        queue_take(3);
        queue_take(5);
        queue_push(8'h55);
        queue_push(8'h0F);
        queue_take(16);
        queue_take(1);

        // random well-formed stream, every 0xFF stuffed
        n = 0;
        while (n < 1850) begin
            if ($urandom_range(0, 99) < 55) begin
                b = ($urandom_range(0, 7) == 0) ? FF_BYTE : 8'($urandom);
                queue_push(b);
                n = n + 1;
                if (b == FF_BYTE) begin
                    if ($urandom_range(0, 3) == 0) begin
                        queue_take(random_count());
                        n = n + 1;
                    end
                    queue_push(STUFF_ZERO);
                    n = n + 1;
                end
            end else begin
                queue_take(random_count());
                n = n + 1;
            end
        end

        // marker at the end: take between the pair, then sticky behavior
        queue_push(FF_BYTE);
        queue_take(2);
        queue_push(8'($urandom_range(1, 255)));
        queue_push(8'h12);
        queue_push(FF_BYTE);
        queue_push(STUFF_ZERO);
        for (n = 0; n < 6; n++) queue_take(random_count());
        queue_take(16);
        queue_take(1);
        queue_take(0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/ubr_pkg.sv
rtl/ubr_front.sv
rtl/ubr_queue.sv
rtl/ubr_back.sv
rtl/unstuffing_bit_reader.sv
sim/tb.sv
